// File: rtl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII block.
// Holds the controller state type, datapath command codes and character constants.
// No dependencies.
package sitda_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_DABBLE,
    CMD_SHIFT
  } cmd_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

endpackage

// File: rtl/sitda_in_if.sv
// Input channel interface: one signed integer per request.
// Depends on nothing; width set by VALUE_BITS.
interface sitda_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/sitda_out_if.sv
// Output channel interface: one ASCII character per request, with an end flag.
// Depends on nothing.
interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// File: rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter (top level).
// Depends on sitda_pkg, sitda_in_if, sitda_out_if and sitda_dabble.
//
// Usage: in_ch takes one two's complement integer of VALUE_BITS bits per request.
// out_ch sends its decimal text, one ASCII character per request, most
// significant first: '-' for a negative value, no leading zeros, a single '0'
// for zero. last marks the final character of each number.
// Conversion: after a request is taken the shift-and-add-three converter shifts in
// all VALUE_BITS magnitude bits, one per cycle; then the first character ('-' or
// the leading nonzero digit) is written into the output register. Digits leave at
// one per cycle while the receiver is ready, once the leading zero digits have
// been shifted out of the BCD register unsent. DIGITS, the digit count of
// 2^(VALUE_BITS-1), sets the width of the BCD register.
// in_ch.ready is high only while no number is in work; it rises again as the
// last character enters the output register, even if it is not yet taken.
// A stalled receiver holds the current character and halts the shift of digits to be sent;
// leading zero digits are still shifted out. Reset: synchronous, clears the controller
// and the output valid; no clearing pass.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  sitda_in_if.sink           in_ch,
  sitda_out_if.source        out_ch
);

  localparam int DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
  localparam int CNT_W  = $clog2(VALUE_BITS);

  sitda_pkg::state_t state, state_next;
  sitda_pkg::cmd_t   cmd;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic             neg;
  logic             started, started_next;
  logic [3:0]       digit;

  logic             ovalid;
  logic [7:0]       ochar;
  logic             olast;

  logic             out_free;
  logic             emit_req;
  logic [7:0]       emit_char;
  logic             emit_last;
  logic             skip;
  logic             conv_done;
  logic             in_take;

  sitda_dabble #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dabble (
    .clk  (clk),
    .cmd  (cmd),
    .value(in_ch.value),
    .digit(digit)
  );

  assign out_free  = !ovalid || out_ch.ready;
  assign conv_done = (cnt == CNT_W'(VALUE_BITS - 1));
  assign skip      = !started && (digit == 4'd0) && (cnt != '0);
  assign in_take   = in_ch.valid && (state == sitda_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      sitda_pkg::ST_IDLE: begin
        if (in_ch.valid) state_next = sitda_pkg::ST_CONV;
      end
      sitda_pkg::ST_CONV: begin
        if (conv_done) state_next = neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
      end
      sitda_pkg::ST_SIGN: begin
        if (out_free) state_next = sitda_pkg::ST_EMIT;
      end
      sitda_pkg::ST_EMIT: begin
        if (!skip && out_free && (cnt == '0)) state_next = sitda_pkg::ST_IDLE;
      end
      default: state_next = sitda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = sitda_pkg::CMD_HOLD;
    cnt_next     = cnt;
    started_next = started;
    emit_req     = 1'b0;
    emit_char    = sitda_pkg::CHAR_ZERO + {4'h0, digit};
    emit_last    = 1'b0;
    unique case (state)
      sitda_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          cmd          = sitda_pkg::CMD_LOAD;
          cnt_next     = '0;
          started_next = 1'b0;
        end
      end
      sitda_pkg::ST_CONV: begin
        cmd      = sitda_pkg::CMD_DABBLE;
        cnt_next = conv_done ? CNT_W'(DIGITS - 1) : cnt + CNT_W'(1);
      end
      sitda_pkg::ST_SIGN: begin
        emit_req  = 1'b1;
        emit_char = sitda_pkg::CHAR_MINUS;
      end
      sitda_pkg::ST_EMIT: begin
        if (skip) begin
          cmd      = sitda_pkg::CMD_SHIFT;
          cnt_next = cnt - CNT_W'(1);
        end else begin
          emit_req  = 1'b1;
          emit_last = (cnt == '0);
          if (out_free) begin
            cmd          = sitda_pkg::CMD_SHIFT;
            cnt_next     = cnt - CNT_W'(1);
            started_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sitda_pkg::ST_IDLE;
      cnt     <= '0;
      started <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      started <= started_next;
      if (out_free) ovalid <= emit_req;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) neg <= in_ch.value[VALUE_BITS-1];
    if (out_free && emit_req) begin
      ochar <= emit_char;
      olast <= emit_last;
    end
  end

  assign in_ch.ready      = (state == sitda_pkg::ST_IDLE);
  assign out_ch.valid     = ovalid;
  assign out_ch.character = ochar;
  assign out_ch.last      = olast;

  a_take_starts_conv: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == sitda_pkg::ST_CONV) && (cnt == '0))
    else $error("accepted request did not start conversion");

  a_conv_exit: assert property (@(posedge clk) disable iff (rst)
    (state == sitda_pkg::ST_CONV) |=> (state == sitda_pkg::ST_CONV) ||
      (state == sitda_pkg::ST_SIGN) || (state == sitda_pkg::ST_EMIT))
    else $error("conversion left to an illegal state");

  a_sign_only_neg: assert property (@(posedge clk) disable iff (rst)
    (state == sitda_pkg::ST_SIGN) |-> neg)
    else $error("sign emitted for non-negative value");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit_req && emit_last && out_free) |=> (state == sitda_pkg::ST_IDLE) && ovalid && olast)
    else $error("last character did not end the number");

endmodule

// File: rtl/sitda_dabble.sv
// Bit-serial binary to BCD converter (shift and add three) with digit shift-out.
// Depends on sitda_pkg for the command codes.
module sitda_dabble #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  sitda_pkg::cmd_t       cmd,
  input  logic [VALUE_BITS-1:0] value,
  output logic [3:0]            digit
);

  localparam int DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
  localparam int BCD_W  = 4 * DIGITS;

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      sitda_pkg::CMD_LOAD: begin
        mag <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
        bcd <= '0;
      end
      sitda_pkg::CMD_DABBLE: begin
        bcd <= {adj[BCD_W-2:0], mag[VALUE_BITS-1]};
        mag <= {mag[VALUE_BITS-2:0], 1'b0};
      end
      sitda_pkg::CMD_SHIFT: begin
        bcd <= {bcd[BCD_W-5:0], 4'h0};
      end
      default: begin
      end
    endcase
  end

  assign digit = bcd[BCD_W-1 -: 4];

endmodule

// File: tb/testbench.sv
// Self-checking bench for signed_int_to_decimal_ascii: each number sent is turned into the
// expected ASCII text, character by character, and compared with what leaves out_ch.
// Depends on sitda_pkg, sitda_in_if, sitda_out_if and the top level of the block.
module testbench;

  localparam int VALUE_BITS = 32;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst;
  logic steady_flow;
  int   mismatches;

  text_char_t pending_text[$];
  text_char_t seen_char;
  text_char_t want_char;

  sitda_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch();
  sitda_out_if out_ch();

  signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void predict_text(input logic signed [VALUE_BITS-1:0] number);
    longint     magnitude;
    logic       negative;
    logic [7:0] digits[$];
    magnitude = number;
    negative  = magnitude < 0;
    if (negative) magnitude = -magnitude;
    do begin
      digits.push_front(sitda_pkg::CHAR_ZERO + 8'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) pending_text.push_back('{sitda_pkg::CHAR_MINUS, 1'b0});
    for (int i = 0; i < digits.size(); i++) begin
      pending_text.push_back('{digits[i], i == digits.size() - 1});
    end
  endfunction

  function automatic void note_mismatch(input string what, input text_char_t want,
                                        input text_char_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected char %h last %b, got char %h last %b", $realtime, what,
               want.character, want.last, seen.character, seen.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen_char = '{out_ch.character, out_ch.last};
      if (pending_text.size() == 0) begin
        note_mismatch("unexpected character", '0, seen_char);
      end else begin
        want_char = pending_text.pop_front();
        if (want_char.character !== seen_char.character || want_char.last !== seen_char.last) begin
          note_mismatch("wrong character", want_char, seen_char);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 11);
  end

  task automatic send_number(input logic signed [VALUE_BITS-1:0] number);
    if (!steady_flow && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 11) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= number;
    do @(posedge clk); while (!in_ch.ready);
    predict_text(number);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] random_number();
    logic [VALUE_BITS-1:0] bits;
    bits = $urandom;
    if ($urandom_range(0, 3) != 0) begin
      bits = bits >> $urandom_range(0, VALUE_BITS - 1);
      if ($urandom_range(0, 1)) bits = -bits;
    end
    return bits;
  endfunction

  task automatic test_directed();
    logic signed [VALUE_BITS-1:0] corners[$];
    corners = '{0, 1, -1, 7, -7, 9, 10, -10, 99, -100, 2147483647, 32'sh80000000,
                -2147483647, 1000000000, -1000000000, 999999999, 123456789,
                -987654321, 32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFE, 32'h80000001};
    foreach (corners[i]) send_number(corners[i]);
  endtask

  task automatic test_random_values();
    repeat (160) send_number(random_number());
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (100) send_number(random_number());
    steady_flow = 1'b0;
  endtask

  task automatic test_digit_boundaries();
    longint power;
    repeat (100) begin
      power = 1;
      repeat ($urandom_range(0, 9)) power = power * 10;
      case ($urandom_range(0, 3))
        0: send_number(VALUE_BITS'(power));
        1: send_number(VALUE_BITS'(power - 1));
        2: send_number(VALUE_BITS'(-power));
        default: send_number(VALUE_BITS'($signed($urandom_range(0, 40)) - 20));
      endcase
    end
  endtask

  initial begin
    mismatches   = 0;
    steady_flow  = 1'b0;
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_values();
    test_back_to_back();
    test_digit_boundaries();
    in_ch.valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

endmodule
